/* src/ac_pulse_skip_modulator_macros.svh */
// assertion macros for the pulse-skip modulator
`ifndef AC_PULSE_SKIP_MODULATOR_MACROS_SVH
`define AC_PULSE_SKIP_MODULATOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define APSM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define APSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/apsm_pkg.sv */
// types, codes and reset values of the pulse-skip modulator
package apsm_pkg;

    localparam int FUNC_W  = 2;
    localparam int TIME_W  = 32;
    localparam int FS_W    = 16;
    localparam int DIV_W   = 8;
    localparam int CNT_W   = 32;
    localparam int GAP_W   = 8;
    localparam int REG_W   = 3;
    localparam int DATA_W  = 32;

    localparam logic [FS_W-1:0]  FULL_SCALE_RST = 16'd100;
    localparam logic [DIV_W-1:0] DIVIDER_RST    = 8'd1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CROSS = 2'd0,
        FUNC_TIMER = 2'd1,
        FUNC_CLEAR = 2'd2
    } t_func;

    typedef enum logic [REG_W-1:0] {
        REG_FULL_SCALE = 3'd0,
        REG_LEVEL      = 3'd1,
        REG_DIVIDER    = 3'd2,
        REG_STOP_LIMIT = 3'd3,
        REG_MIN_GAP    = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [FS_W-1:0]  full_scale;
        logic [FS_W-1:0]  level;
        logic [DIV_W-1:0] crossing_divider;
        logic [CNT_W-1:0] stop_limit;
        logic [GAP_W-1:0] min_gap_ms;
    } t_cfg;

    typedef struct packed {
        logic [FS_W-1:0]   accumulator;
        logic [DIV_W-1:0]  divide_count;
        logic [CNT_W-1:0]  fire_total;
        logic              skip_flag;
        logic [TIME_W-1:0] last_accept_ms;
        logic              drive_level;
    } t_state;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [TIME_W-1:0] now_ms;
    } t_in_word;

    typedef struct packed {
        logic             drive;
        logic             accepted;
        logic [CNT_W-1:0] fired_count;
    } t_out_word;

endpackage

/* src/apsm_intf.sv */
// handshake channels of the pulse-skip modulator
interface apsm_in_if;
    import apsm_pkg::*;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [TIME_W-1:0] now_ms;
    modport source (output valid, output func, output now_ms, input ready);
    modport sink   (input valid, input func, input now_ms, output ready);
endinterface

interface apsm_out_if;
    import apsm_pkg::*;
    logic             valid;
    logic             ready;
    logic             drive;
    logic             accepted;
    logic [CNT_W-1:0] fired_count;
    modport source (output valid, output drive, output accepted, output fired_count,
                    input ready);
    modport sink   (input valid, input drive, input accepted, input fired_count,
                    output ready);
endinterface

interface apsm_cfg_if;
    import apsm_pkg::*;
    logic              valid;
    logic              ready;
    logic [REG_W-1:0]  index;
    logic [DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/ac_pulse_skip_modulator.sv */
// top level of the pulse-skip modulator
//
// channel   dir  handshake        word
// i_in      in   valid / ready    func, now_ms
// o_out     out  valid / ready    drive, accepted, fired_count
// i_cfg     in   valid / ready    index, data (always ready)
//
// one word per cycle sustained while results are taken
// the rate is set by the state update between input and result register
// reset: registers to defaults, state cleared, skip flag set, both stages empty
// a stalled result holds its register and the input register behind it;
// input ready drops only when both are full
`include "ac_pulse_skip_modulator_macros.svh"

module ac_pulse_skip_modulator (
    input  logic i_clk,
    input  logic i_rst_n,
    apsm_in_if.sink    i_in,
    apsm_out_if.source o_out,
    apsm_cfg_if.sink   i_cfg
);
    import apsm_pkg::*;

    logic      r_s1_valid;
    t_in_word  r_s1;
    logic      r_out_valid;
    t_out_word r_out;
    t_state    r_state;
    t_cfg      r_cfg;

    t_state    n_state;
    t_out_word n_out;
    t_cfg      n_cfg;
    t_in_word  in_word;
    logic      s1_adv;
    logic      in_fire;
    logic      cfg_fire;
    logic [FS_W-1:0] cfg_lo;

    assign s1_adv   = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_fire  = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign cfg_fire = i_cfg.valid && i_cfg.ready;
    assign cfg_lo   = i_cfg.data[FS_W-1:0];

    assign in_word.func   = i_in.func;
    assign in_word.now_ms = i_in.now_ms;

    apsm_core u_core (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_word   (r_s1),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_comb begin
        n_cfg = r_cfg;
        if (cfg_fire) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_FULL_SCALE: n_cfg.full_scale = cfg_lo;
                REG_LEVEL:      n_cfg.level = (cfg_lo < r_cfg.full_scale) ? cfg_lo
                                                                          : r_cfg.full_scale;
                REG_DIVIDER:    n_cfg.crossing_divider = i_cfg.data[DIV_W-1:0];
                REG_STOP_LIMIT: n_cfg.stop_limit = i_cfg.data[CNT_W-1:0];
                REG_MIN_GAP:    n_cfg.min_gap_ms = i_cfg.data[GAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{accumulator: '0, divide_count: '0, fire_total: '0,
                             skip_flag: 1'b1, last_accept_ms: '0, drive_level: 1'b0};
            r_cfg       <= '{full_scale: FULL_SCALE_RST, level: '0,
                             crossing_divider: DIVIDER_RST, stop_limit: '0,
                             min_gap_ms: '0};
        end else begin
            r_cfg <= n_cfg;
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1 <= in_word;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.drive       = r_out.drive;
    assign o_out.accepted    = r_out.accepted;
    assign o_out.fired_count = r_out.fired_count;

    // result register mirrors the state left by its word
    `APSM_ASSERT_SAME(a_out_matches_state, i_clk, i_rst_n, r_out_valid, (r_out.fired_count == r_state.fire_total) && (r_out.drive == r_state.drive_level), "result word out of step with state")
    // state moves only with a processed word
    `APSM_ASSERT_NEXT(a_state_hold, i_clk, i_rst_n, !s1_adv, $stable(r_state), "state changed without a word")
    // level write saturates at full scale
    `APSM_ASSERT_NEXT(a_level_sat, i_clk, i_rst_n, cfg_fire && (i_cfg.index == REG_LEVEL), r_cfg.level <= r_cfg.full_scale, "level above full scale after write")
    // input stalls only with both stages full
    `APSM_ASSERT_SAME(a_ready_low, i_clk, i_rst_n, !i_in.ready, r_s1_valid && r_out_valid && !o_out.ready, "input stalled with room")

endmodule

/* src/apsm_core.sv */
// event decode, gap filter, divider and accumulator decision
module apsm_core (
    input  apsm_pkg::t_state    i_state,
    input  apsm_pkg::t_cfg      i_cfg,
    input  apsm_pkg::t_in_word  i_word,
    output apsm_pkg::t_state    o_state,
    output apsm_pkg::t_out_word o_result
);
    import apsm_pkg::*;

    logic [FS_W:0]     sum;
    logic [FS_W:0]     fs_ext;
    logic [FS_W:0]     reduced;
    logic              ge;
    logic              over;
    logic [FS_W-1:0]   dec_acc;
    logic [CNT_W-1:0]  dec_fire;
    logic              dec_skip;
    logic [TIME_W-1:0] gap_lim;
    logic              reject;
    logic [DIV_W-1:0]  top;
    logic              accepted;

    assign sum      = {1'b0, i_state.accumulator} + {1'b0, i_cfg.level};
    assign fs_ext   = {1'b0, i_cfg.full_scale};
    assign ge       = sum >= fs_ext;
    assign reduced  = ge ? (sum - fs_ext) : sum;
    assign over     = reduced > fs_ext;
    assign dec_acc  = over ? '0 : reduced[FS_W-1:0];
    assign dec_fire = i_state.fire_total + CNT_W'(1);
    assign dec_skip = !ge || ((i_cfg.stop_limit != '0) && (dec_fire > i_cfg.stop_limit));

    assign gap_lim = i_word.now_ms - {{(TIME_W-GAP_W){1'b0}}, i_cfg.min_gap_ms};
    assign reject  = (i_cfg.min_gap_ms != '0) && (gap_lim < i_state.last_accept_ms)
                     && (i_word.now_ms >= i_state.last_accept_ms);
    assign top     = i_cfg.crossing_divider - DIV_W'(1);

    always_comb begin
        logic decide;
        decide   = 1'b0;
        o_state  = i_state;
        accepted = 1'b0;
        unique case (t_func'(i_word.func))
            FUNC_CROSS: begin
                if (!reject) begin
                    accepted               = 1'b1;
                    o_state.last_accept_ms = i_word.now_ms;
                    if (i_cfg.crossing_divider == '0) begin
                        o_state.divide_count = i_state.divide_count + DIV_W'(1);
                        decide               = 1'b1;
                    end else if (i_state.divide_count < top) begin
                        o_state.divide_count = i_state.divide_count + DIV_W'(1);
                    end else begin
                        o_state.divide_count = i_state.divide_count - top;
                        decide               = 1'b1;
                    end
                    if (decide) begin
                        o_state.accumulator = dec_acc;
                        o_state.skip_flag   = dec_skip;
                        if (ge) begin
                            o_state.fire_total = dec_fire;
                        end
                    end
                    o_state.drive_level = !o_state.skip_flag;
                end
            end
            FUNC_TIMER: begin
                o_state.drive_level = 1'b0;
            end
            FUNC_CLEAR: begin
                o_state.fire_total = '0;
            end
            default: begin
            end
        endcase
    end

    assign o_result.drive       = o_state.drive_level;
    assign o_result.accepted    = accepted;
    assign o_result.fired_count = o_state.fire_total;

endmodule

/* verif/tb_ac_pulse_skip_modulator.sv */
// testbench of the pulse-skip modulator: directed corners, then random streams with and without back-pressure
module tb_ac_pulse_skip_modulator;
    timeunit 1ns;
    timeprecision 1ps;

    import apsm_pkg::*;

    localparam int LIMIT_CYCLES  = 600000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 80;
    localparam int SEGMENTS      = 8;
    localparam int SEGMENT_WORDS = 235;
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

    logic clk;
    logic rst_n;

    apsm_in_if  in_ch ();
    apsm_out_if out_ch ();
    apsm_cfg_if cfg_ch ();

    ac_pulse_skip_modulator i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    t_cfg        mod_cfg;
    t_state      mod_state;
    t_out_word   due_gate_words[$];
    logic [TIME_W-1:0] mains_ms;
    int          errors = 0;
    int          cycles = 0;
    int          send_idle_pct;
    int          recv_stall_pct;
    logic        hold_on;
    event        hold_go;

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // long receiver hold-off
    always begin
        @(hold_go);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= !hold_on && ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    always @(posedge clk) begin : check_blk
        t_out_word want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (due_gate_words.size() == 0) begin
                errors++;
                $display("%0t unexpected word: expected none, actual %0b/%0b/%0d",
                         $time, out_ch.drive, out_ch.accepted, out_ch.fired_count);
            end else begin
                want = due_gate_words.pop_front();
                if (out_ch.drive !== want.drive) begin
                    errors++;
                    $display("%0t drive: expected %0b, actual %0b",
                             $time, want.drive, out_ch.drive);
                end
                if (out_ch.accepted !== want.accepted) begin
                    errors++;
                    $display("%0t accepted: expected %0b, actual %0b",
                             $time, want.accepted, out_ch.accepted);
                end
                if (out_ch.fired_count !== want.fired_count) begin
                    errors++;
                    $display("%0t fired_count: expected %0d, actual %0d",
                             $time, want.fired_count, out_ch.fired_count);
                end
            end
        end
    end

    function automatic void reset_mirror();
        mod_cfg.full_scale       = FULL_SCALE_RST;
        mod_cfg.level            = '0;
        mod_cfg.crossing_divider = DIVIDER_RST;
        mod_cfg.stop_limit       = '0;
        mod_cfg.min_gap_ms       = '0;
        mod_state.accumulator    = '0;
        mod_state.divide_count   = '0;
        mod_state.fire_total     = '0;
        mod_state.skip_flag      = 1'b1;
        mod_state.last_accept_ms = '0;
        mod_state.drive_level    = 1'b0;
    endfunction

    function automatic void mirror_reg(input logic [REG_W-1:0] idx, input logic [DATA_W-1:0] data);
        logic [FS_W-1:0] v;
        v = data[FS_W-1:0];
        case (idx)
            REG_FULL_SCALE: mod_cfg.full_scale = v;
            REG_LEVEL: mod_cfg.level = (v < mod_cfg.full_scale) ? v : mod_cfg.full_scale;
            REG_DIVIDER: mod_cfg.crossing_divider = data[DIV_W-1:0];
            REG_STOP_LIMIT: mod_cfg.stop_limit = data[CNT_W-1:0];
            REG_MIN_GAP: mod_cfg.min_gap_ms = data[GAP_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void decide_half_cycle();
        logic [FS_W:0] sum;
        logic [FS_W:0] fs;
        fs  = {1'b0, mod_cfg.full_scale};
        sum = {1'b0, mod_state.accumulator} + {1'b0, mod_cfg.level};
        if (sum >= fs) begin
            sum = sum - fs;
            mod_state.skip_flag = 1'b0;
        end else begin
            mod_state.skip_flag = 1'b1;
        end
        // level left above a lowered full scale
        if (sum > fs) begin
            sum = '0;
            mod_state.skip_flag = 1'b0;
        end
        mod_state.accumulator = sum[FS_W-1:0];
        if (!mod_state.skip_flag) begin
            mod_state.fire_total = mod_state.fire_total + 1'b1;
            if (mod_cfg.stop_limit != 0 && mod_state.fire_total > mod_cfg.stop_limit) begin
                mod_state.skip_flag = 1'b1;
            end
        end
    endfunction

    function automatic t_out_word gate_event(input logic [FUNC_W-1:0] func,
                                             input logic [TIME_W-1:0] now);
        t_out_word         w;
        logic [TIME_W-1:0] lim;
        logic [DIV_W-1:0]  top;
        logic              pass;
        pass = 1'b0;
        case (func)
            FUNC_CROSS: begin
                pass = 1'b1;
                if (mod_cfg.min_gap_ms != 0) begin
                    lim = now - {{(TIME_W-GAP_W){1'b0}}, mod_cfg.min_gap_ms};
                    if (lim < mod_state.last_accept_ms && now >= mod_state.last_accept_ms) begin
                        pass = 1'b0;
                    end
                end
                if (pass) begin
                    mod_state.last_accept_ms = now;
                    if (mod_cfg.crossing_divider == 0) begin
                        mod_state.divide_count = mod_state.divide_count + 1'b1;
                        decide_half_cycle();
                    end else begin
                        top = mod_cfg.crossing_divider - 1'b1;
                        if (mod_state.divide_count < top) begin
                            mod_state.divide_count = mod_state.divide_count + 1'b1;
                        end else begin
                            mod_state.divide_count = mod_state.divide_count - top;
                            decide_half_cycle();
                        end
                    end
                    mod_state.drive_level = !mod_state.skip_flag;
                end
            end
            FUNC_TIMER: mod_state.drive_level = 1'b0;
            FUNC_CLEAR: mod_state.fire_total = '0;
            default: ;
        endcase
        w.drive       = mod_state.drive_level;
        w.accepted    = pass;
        w.fired_count = mod_state.fire_total;
        return w;
    endfunction

    task automatic send_event(input logic [FUNC_W-1:0] func, input logic [TIME_W-1:0] now);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.func   <= func;
        in_ch.now_ms <= now;
        do @(posedge clk); while (!in_ch.ready);
        due_gate_words.push_back(gate_event(func, now));
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (due_gate_words.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [REG_W-1:0] idx, input logic [DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        mirror_reg(idx, data);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic cross_at(input logic [TIME_W-1:0] now);
        send_event(FUNC_CROSS, now);
    endtask

    task automatic test_defaults();
        cross_at('0);
        send_event(FUNC_TIMER, '1);
        send_event(FUNC_CLEAR, '1);
        send_event(FUNC_SPARE, '1);
        settle();
        for (int r = REG_MIN_GAP + 1; r < (1 << REG_W); r++) begin
            cfg_write(r[REG_W-1:0], $urandom());
        end
        cross_at(32'd5);
    endtask

    task automatic test_full_power_stop();
        settle();
        cfg_write(REG_FULL_SCALE, 32'd4);
        cfg_write(REG_LEVEL, 32'd4);
        cfg_write(REG_STOP_LIMIT, 32'd1);
        cross_at(32'd10);
        cross_at(32'd20);
        send_event(FUNC_TIMER, 32'd21);
        send_event(FUNC_CLEAR, 32'd22);
        cross_at(32'd30);
        send_event(FUNC_TIMER, 32'd31);
        settle();
        cfg_write(REG_STOP_LIMIT, 32'd0);
    endtask

    task automatic test_divider_edges();
        settle();
        cfg_write(REG_DIVIDER, 32'd0);
        cross_at(32'd40);
        cross_at(32'd50);
        settle();
        cfg_write(REG_DIVIDER, 32'd255);
        for (int i = 0; i < 3; i++) begin
            cross_at(32'd60 + i);
        end
        settle();
        // count left above the lowered divider
        cfg_write(REG_DIVIDER, 32'd2);
        cross_at(32'd70);
        cross_at(32'd80);
    endtask

    task automatic test_scale_edges();
        settle();
        cfg_write(REG_DIVIDER, 32'd1);
        cfg_write(REG_FULL_SCALE, 32'hFFFF);
        cfg_write(REG_LEVEL, 32'hFFFF);
        cfg_write(REG_FULL_SCALE, 32'd10);
        cross_at(32'd90);
        settle();
        cfg_write(REG_FULL_SCALE, 32'd0);
        cross_at(32'd100);
        settle();
        cfg_write(REG_LEVEL, 32'd0);
        cross_at(32'd110);
    endtask

    task automatic test_gap_filter();
        settle();
        cfg_write(REG_FULL_SCALE, 32'd100);
        cfg_write(REG_LEVEL, 32'd50);
        cfg_write(REG_MIN_GAP, 32'd255);
        cross_at(32'hFFFF_FF00);
        cross_at(32'hFFFF_FF64);
        cross_at(32'hFFFF_FFFF);
        cross_at(32'h0000_0010);
        cross_at(32'h0000_0015);
        cross_at(32'h0000_0113);
    endtask

    task automatic test_stall_fill();
        settle();
        cfg_write(REG_FULL_SCALE, 32'd7);
        cfg_write(REG_LEVEL, 32'd3);
        cfg_write(REG_MIN_GAP, 32'd0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mains_ms = 32'd1000;
        -> hold_go;
        for (int i = 0; i < 40; i++) begin
            mains_ms = mains_ms + 10;
            cross_at(mains_ms);
        end
        settle();
    endtask

    task automatic random_setup();
        logic [FS_W-1:0] fs;
        logic [FS_W-1:0] lv;
        logic [DIV_W-1:0] dv;
        logic [CNT_W-1:0] sl;
        logic [GAP_W-1:0] gp;
        settle();
        case ($urandom_range(9, 0))
            0: fs = '0;
            1: fs = FS_W'(1);
            2: fs = '1;
            3, 4: fs = FS_W'($urandom_range(8, 2));
            default: fs = FS_W'($urandom_range(400, 10));
        endcase
        case ($urandom_range(3, 0))
            0: lv = '0;
            1: lv = fs;
            2: lv = FS_W'($urandom_range(fs, 0));
            default: lv = '1;
        endcase
        case ($urandom_range(5, 0))
            0: dv = '0;
            1, 2: dv = DIV_W'(1);
            3: dv = DIV_W'($urandom_range(3, 2));
            4: dv = DIV_W'($urandom_range(20, 4));
            default: dv = '1;
        endcase
        case ($urandom_range(3, 0))
            0, 1: sl = '0;
            2: sl = CNT_W'($urandom_range(40, 1));
            default: sl = $urandom();
        endcase
        case ($urandom_range(3, 0))
            0: gp = '0;
            1: gp = GAP_W'($urandom_range(12, 6));
            2: gp = '1;
            default: gp = GAP_W'($urandom_range(255, 1));
        endcase
        // level first leaves it above a lowered full scale
        if ($urandom_range(3, 0) == 0) begin
            cfg_write(REG_LEVEL, {16'd0, lv});
            cfg_write(REG_FULL_SCALE, {16'd0, fs});
        end else begin
            cfg_write(REG_FULL_SCALE, {16'd0, fs});
            cfg_write(REG_LEVEL, {16'd0, lv});
        end
        cfg_write(REG_DIVIDER, {24'd0, dv});
        cfg_write(REG_STOP_LIMIT, sl);
        cfg_write(REG_MIN_GAP, {24'd0, gp});
        if ($urandom_range(3, 0) == 0) begin
            mains_ms = '1 - $urandom_range(2000, 0);
        end else begin
            mains_ms = $urandom();
        end
    endtask

    task automatic random_event(output bit counted);
        int pick;
        int step;
        int gap;
        pick = $urandom_range(99, 0);
        gap  = mod_cfg.min_gap_ms;
        counted = 1'b1;
        if (pick < 78) begin
            step = $urandom_range(99, 0);
            if (step < 70) begin
                mains_ms = mains_ms + gap + $urandom_range(12, 0);
            end else if (step < 88) begin
                mains_ms = mains_ms + $urandom_range(gap, 0);
            end else if (step < 94) begin
                mains_ms = mains_ms - $urandom_range(300, 0);
            end else begin
                mains_ms = $urandom();
            end
            cross_at(mains_ms);
        end else if (pick < 88) begin
            send_event(FUNC_TIMER, $urandom());
        end else if (pick < 95) begin
            send_event(FUNC_CLEAR, $urandom());
        end else begin
            send_event(FUNC_SPARE, $urandom());
            counted = 1'b0;
        end
    endtask

    task automatic test_random_phases();
        int sent;
        bit counted;
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            random_setup();
            case (seg % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            sent = 0;
            while (sent < SEGMENT_WORDS) begin
                random_event(counted);
                if (counted) begin
                    sent++;
                end
                // sender pause until all results are back
                if (seg % 2 == 1 && sent == SEGMENT_WORDS / 2 && counted) begin
                    settle();
                end
            end
        end
    endtask

    initial begin
        in_ch.valid    = 1'b0;
        in_ch.func     = FUNC_CROSS;
        in_ch.now_ms   = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = REG_FULL_SCALE;
        cfg_ch.data    = '0;
        out_ch.ready   = 1'b0;
        hold_on        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mains_ms       = '0;
        rst_n          = 1'b0;
        reset_mirror();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_full_power_stop();
        test_divider_edges();
        test_scale_edges();
        test_gap_filter();
        test_stall_fill();
        test_random_phases();

        settle();
        if (errors == 0 && due_gate_words.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

/* sim.f */
+incdir+src
src/apsm_pkg.sv
src/apsm_intf.sv
src/apsm_core.sv
src/ac_pulse_skip_modulator.sv
verif/tb_ac_pulse_skip_modulator.sv
